/* design/rtfs_pkg.sv */
// Shared types and constants for the radio tuner frequency stepper.
`timescale 1ns / 1ps

package rtfs_pkg;

  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned BAND_W  = 4;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;

  // Acceleration count thresholds
  localparam logic [CNT_W-1:0] ACCEL_MID  = CNT_W'(6);
  localparam logic [CNT_W-1:0] ACCEL_HIGH = CNT_W'(12);

  localparam logic [FREQ_W-1:0] FREQ_LOW_RST  = FREQ_W'(8750);
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RST = FREQ_W'(10800);
  localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(10);

  localparam logic [BAND_W-1:0] BAND_FM = BAND_W'(0);
  localparam logic [BAND_W-1:0] BAND_MW = BAND_W'(1);

  typedef enum logic [2:0] {
    FN_TUNE_CUR  = 3'd0,
    FN_TUNE_UP   = 3'd1,
    FN_TUNE_DOWN = 3'd2,
    FN_SCAN_NEXT = 3'd3,
    FN_SCAN_PREV = 3'd4,
    FN_SCAN_ALL  = 3'd5,
    FN_ALIGN     = 3'd6,
    FN_LOAD      = 3'd7
  } func_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FREQ_LOW  = 3'd0,
    CFG_FREQ_HIGH = 3'd1,
    CFG_STEP_SIZE = 3'd2,
    CFG_BAND      = 3'd3,
    CFG_STOP_FREQ = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  // Control and status between sequencer and remainder unit
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [STEP_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] rem;
  } rem_rsp_t;

endpackage

/* design/rtfs_rem.sv */
// Bit-serial restoring remainder unit: 16-bit dividend by 8-bit divisor.
`timescale 1ns / 1ps

module rtfs_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtfs_pkg::rem_req_t req_i,
  output rtfs_pkg::rem_rsp_t rsp_o
);
  import rtfs_pkg::*;

  localparam int unsigned ITER_W = $clog2(FREQ_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [FREQ_W-1:0] dvd_q, dvd_d;
  logic [STEP_W-1:0] div_q, div_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W:0]   trial;

  assign trial = {rem_q, dvd_q[FREQ_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      iter_d = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = STEP_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[STEP_W-1:0];
      end
      dvd_d  = {dvd_q[FREQ_W-2:0], 1'b0};
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(FREQ_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* design/radio_tuner_frequency_stepper.sv */
// Top level of the radio tuner frequency stepper: config, sequencer and result register.
`timescale 1ns / 1ps

// Each command request passes through the step multiply (ST_MUL), scaling by
// band and acceleration range (ST_SCALE), a wait on the bit-serial remainder
// unit used by MW grid alignment (ST_DIV; it runs for every command), and
// forming the new frequency and loading it into the output register (ST_FIN,
// which waits while the output still holds a result that has not been taken).
// One request is in flight at a time; in_ready_o is high only while the
// sequencer is idle, so a new request is accepted only once the last result is
// loaded, and a finished result can wait on the output while the next request is accepted.
// Config registers may be written only while no request is in flight.

module radio_tuner_frequency_stepper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [rtfs_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [rtfs_pkg::CFG_DW-1:0] cfg_wdata_i,
  // command requests
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  func_i,
  input  logic [rtfs_pkg::CNT_W-1:0]  accel_count_i,
  input  logic                        station_valid_i,
  input  logic [rtfs_pkg::FREQ_W-1:0] load_value_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rtfs_pkg::FREQ_W-1:0] frequency_o,
  output logic                        tune_am_o,
  output logic                        scan_finished_o,
  output logic [rtfs_pkg::CNT_W-1:0]  channel_count_o
);
  import rtfs_pkg::*;

  // config
  logic [FREQ_W-1:0] freq_low_q, freq_high_q, stop_freq_q;
  logic [STEP_W-1:0] step_size_q;
  logic [BAND_W-1:0] band_q;

  // architectural state
  logic [FREQ_W-1:0] cur_freq_q, cur_freq_d;
  logic [CNT_W-1:0]  chan_q, chan_d;

  // sequencer
  state_e            state_q, state_d;
  func_e             func_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              stn_q;
  logic [FREQ_W-1:0] load_q;
  logic [FREQ_W-1:0] prod_q, prod_d;
  logic [FREQ_W-1:0] step_q, step_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [FREQ_W-1:0] out_freq_q;
  logic              out_am_q, out_fin_q, fin_d;
  logic [CNT_W-1:0]  out_chan_q;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic              accept, fin_load;
  logic [FREQ_W-1:0] mul5, scan_up, scan_dn, tune_up, tune_dn, wrap_f;
  logic              low_side;

  function automatic logic [FREQ_W-1:0] clamp_band(input logic [FREQ_W-1:0] f,
                                                   input logic [FREQ_W-1:0] lo,
                                                   input logic [FREQ_W-1:0] hi);
    logic [FREQ_W-1:0] r;
    r = f;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_low_q  <= FREQ_LOW_RST;
      freq_high_q <= FREQ_HIGH_RST;
      step_size_q <= STEP_RST;
      band_q      <= BAND_FM;
      stop_freq_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FREQ_LOW:  freq_low_q  <= cfg_wdata_i;
        CFG_FREQ_HIGH: freq_high_q <= cfg_wdata_i;
        CFG_STEP_SIZE: step_size_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_BAND:      band_q      <= cfg_wdata_i[BAND_W-1:0];
        CFG_STOP_FREQ: stop_freq_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request capture; a zero count acts as one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      cnt_q  <= (accel_count_i == '0) ? CNT_W'(1) : accel_count_i;
      stn_q  <= station_valid_i;
      load_q <= load_value_i;
    end
    prod_q <= prod_d;
    step_q <= step_d;
  end

  // accelerated step: product, then x1/x5/x10/x20 by range and band (zero for FM and MW at the high range)
  assign prod_d = (state_q == ST_MUL) ? FREQ_W'(step_size_q) * FREQ_W'(cnt_q) : prod_q;
  assign mul5   = prod_q + {prod_q[FREQ_W-3:0], 2'b00};

  always_comb begin
    step_d = step_q;
    if (state_q == ST_SCALE) begin
      if (cnt_q < ACCEL_MID) begin
        step_d = prod_q;
      end else if (cnt_q < ACCEL_HIGH) begin
        step_d = (band_q < 2) ? mul5 : {mul5[FREQ_W-2:0], 1'b0};
      end else begin
        step_d = (band_q < 2) ? '0 : {mul5[FREQ_W-3:0], 2'b00};
      end
    end
  end

  // distance to the band's lower edge, fed to the remainder unit
  assign low_side         = cur_freq_q < freq_low_q;
  assign rem_req.start    = (state_q == ST_SCALE);
  assign rem_req.dividend = low_side ? (freq_low_q - cur_freq_q) : (cur_freq_q - freq_low_q);
  assign rem_req.divisor  = step_size_q;

  rtfs_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   if (rem_rsp.done) state_d = ST_FIN;
      ST_FIN:   if (fin_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // new frequency
  assign tune_up = cur_freq_q + step_q;
  assign tune_dn = cur_freq_q - step_q;
  assign scan_up = cur_freq_q + FREQ_W'(step_size_q);
  assign scan_dn = cur_freq_q - FREQ_W'(step_size_q);

  always_comb begin
    cur_freq_d = cur_freq_q;
    chan_d     = chan_q;
    fin_d      = 1'b0;
    wrap_f     = '0;
    case (func_q)
      FN_TUNE_CUR:  cur_freq_d = clamp_band(cur_freq_q, freq_low_q, freq_high_q);
      FN_TUNE_UP:   cur_freq_d = clamp_band(tune_up, freq_low_q, freq_high_q);
      FN_TUNE_DOWN: cur_freq_d = clamp_band(tune_dn, freq_low_q, freq_high_q);
      FN_SCAN_NEXT, FN_SCAN_PREV: begin
        if (func_q == FN_SCAN_NEXT) begin
          wrap_f = (scan_up > freq_high_q) ? freq_low_q : scan_up;
        end else begin
          wrap_f = (scan_dn < freq_low_q) ? freq_high_q : scan_dn;
        end
        if (wrap_f == stop_freq_q) begin
          cur_freq_d = clamp_band(wrap_f, freq_low_q, freq_high_q);
          fin_d      = 1'b1;
        end else begin
          cur_freq_d = wrap_f;
          fin_d      = stn_q;
        end
      end
      FN_SCAN_ALL: begin
        if (scan_up > freq_high_q) begin
          cur_freq_d = freq_low_q;
          chan_d     = chan_q - CNT_W'(1);
          fin_d      = 1'b1;
        end else begin
          cur_freq_d = scan_up;
          fin_d      = stn_q;
        end
      end
      FN_ALIGN: begin
        if (band_q == BAND_MW && step_size_q != '0) begin
          cur_freq_d = low_side ? cur_freq_q + FREQ_W'(rem_rsp.rem)
                                : cur_freq_q - FREQ_W'(rem_rsp.rem);
        end
      end
      FN_LOAD:  cur_freq_d = load_q;
      default:  cur_freq_d = load_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (fin_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_freq_q  <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fin_load) begin
        cur_freq_q <= cur_freq_d;
        chan_q     <= chan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_freq_q <= cur_freq_d;
      out_am_q   <= (band_q != BAND_FM);
      out_fin_q  <= fin_d;
      out_chan_q <= chan_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frequency_o     = out_freq_q;
  assign tune_am_o       = out_am_q;
  assign scan_finished_o = out_fin_q;
  assign channel_count_o = out_chan_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the radio tuner frequency stepper.
`timescale 1ns / 1ps

module tb_top;
  import rtfs_pkg::*;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              am;
    logic              fin;
    logic [CNT_W-1:0]  chan;
  } tune_result_t;

  // One line of the directed plan: either a register write or a request
  typedef struct packed {
    bit                is_cfg;
    cfg_idx_e          reg_sel;
    logic [CFG_DW-1:0] wdata;
    func_e             fn;
    logic [CNT_W-1:0]  accel;
    logic              stn;
    logic [FREQ_W-1:0] load;
    bit                typed;
    tune_result_t      want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [CFG_DW-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [2:0]          func_i;
  logic [CNT_W-1:0]    accel_count_i;
  logic                station_valid_i;
  logic [FREQ_W-1:0]   load_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [FREQ_W-1:0]   frequency_o;
  logic                tune_am_o;
  logic                scan_finished_o;
  logic [CNT_W-1:0]    channel_count_o;

  // Shadow copy of the tuner registers and state
  logic [FREQ_W-1:0] reg_low, reg_high, reg_stop;
  logic [STEP_W-1:0] reg_step;
  logic [BAND_W-1:0] reg_band;
  logic [FREQ_W-1:0] tuned_freq;
  logic [CNT_W-1:0]  chan_total;

  tune_result_t pending_results[$];
  plan_row_t    plan[$];
  int unsigned  fail_count;
  int unsigned  idle_pct;

  radio_tuner_frequency_stepper dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .accel_count_i   (accel_count_i),
    .station_valid_i (station_valid_i),
    .load_value_i    (load_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frequency_o     (frequency_o),
    .tune_am_o       (tune_am_o),
    .scan_finished_o (scan_finished_o),
    .channel_count_o (channel_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("[radio_tuner_frequency_stepper] ERROR");
    $finish;
  end

  function automatic logic [FREQ_W-1:0] band_clamp(logic [FREQ_W-1:0] f);
    if (f > reg_high) f = reg_high;
    if (f < reg_low) f = reg_low;
    return f;
  endfunction

  function automatic logic [FREQ_W-1:0] accel_step(logic [CNT_W-1:0] cnt);
    int unsigned c, s;
    c = (cnt == '0) ? 1 : cnt;
    s = 0;
    if (reg_band < 2) begin
      // FM and MW stop moving once the key has been held long
      if (c < ACCEL_MID) s = reg_step * c;
      else if (c < ACCEL_HIGH) s = reg_step * c * 5;
    end else begin
      if (c < ACCEL_MID) s = reg_step * c;
      else if (c < ACCEL_HIGH) s = reg_step * c * 10;
      else s = reg_step * c * 20;
    end
    return s[FREQ_W-1:0];
  endfunction

  // Advances the shadow state by one request and returns the result it gives
  function automatic tune_result_t tuner_predict(func_e fn, logic [CNT_W-1:0] cnt,
                                                 logic stn, logic [FREQ_W-1:0] load);
    tune_result_t r;
    logic [FREQ_W-1:0] f;
    logic fin;
    f = tuned_freq;
    fin = 1'b0;
    case (fn)
      FN_TUNE_CUR:  f = band_clamp(f);
      FN_TUNE_UP:   f = band_clamp(FREQ_W'(f + accel_step(cnt)));
      FN_TUNE_DOWN: f = band_clamp(FREQ_W'(f - accel_step(cnt)));
      FN_SCAN_NEXT, FN_SCAN_PREV: begin
        if (fn == FN_SCAN_NEXT) begin
          f = FREQ_W'(f + reg_step);
          if (f > reg_high) f = reg_low;
        end else begin
          f = FREQ_W'(f - reg_step);
          if (f < reg_low) f = reg_high;
        end
        if (f == reg_stop) begin
          f = band_clamp(f);
          fin = 1'b1;
        end else begin
          fin = stn;
        end
      end
      FN_SCAN_ALL: begin
        f = FREQ_W'(f + reg_step);
        if (f > reg_high) begin
          f = reg_low;
          chan_total = chan_total - 1'b1;
          fin = 1'b1;
        end else begin
          fin = stn;
        end
      end
      FN_ALIGN: begin
        if (reg_band == BAND_MW && reg_step != '0) begin
          if (f >= reg_low) f = f - FREQ_W'((f - reg_low) % reg_step);
          else f = f + FREQ_W'((reg_low - f) % reg_step);
        end
      end
      default: f = load;
    endcase
    tuned_freq = f;
    r.freq = f;
    r.am   = (reg_band != BAND_FM);
    r.fin  = fin;
    r.chan = chan_total;
    return r;
  endfunction

  function automatic plan_row_t row_cmd(func_e fn, logic [CNT_W-1:0] cnt, logic stn,
                                        logic [FREQ_W-1:0] load);
    plan_row_t r;
    r = '0;
    r.fn    = fn;
    r.accel = cnt;
    r.stn   = stn;
    r.load  = load;
    return r;
  endfunction

  function automatic plan_row_t row_known(func_e fn, logic [CNT_W-1:0] cnt, logic stn,
                                          logic [FREQ_W-1:0] load, logic [FREQ_W-1:0] freq,
                                          logic am, logic fin, logic [CNT_W-1:0] chan);
    plan_row_t r;
    r = row_cmd(fn, cnt, stn, load);
    r.typed     = 1'b1;
    r.want.freq = freq;
    r.want.am   = am;
    r.want.fin  = fin;
    r.want.chan = chan;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(cfg_idx_e idx, logic [CFG_DW-1:0] v);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = idx;
    r.wdata   = v;
    return r;
  endfunction

  task automatic send_command(plan_row_t r);
    tune_result_t exp_res;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    func_i          <= r.fn;
    accel_count_i   <= r.accel;
    station_valid_i <= r.stn;
    load_value_i    <= r.load;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_res = tuner_predict(r.fn, r.accel, r.stn, r.load);
    if (r.typed) exp_res = r.want;
    pending_results.push_back(exp_res);
  endtask

  // Register writes only go in once every request has come back
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_FREQ_LOW:  reg_low  = v;
      CFG_FREQ_HIGH: reg_high = v;
      CFG_STEP_SIZE: reg_step = v[STEP_W-1:0];
      CFG_BAND:      reg_band = v[BAND_W-1:0];
      CFG_STOP_FREQ: reg_stop = v;
      default: ;
    endcase
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    tune_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        if (fail_count < 10)
          $display("result with no request pending: freq=%0d am=%0b fin=%0b chan=%0d",
                   frequency_o, tune_am_o, scan_finished_o, channel_count_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (frequency_o !== want.freq || tune_am_o !== want.am ||
            scan_finished_o !== want.fin || channel_count_o !== want.chan) begin
          if (fail_count < 10)
            $display("mismatch: exp freq=%0d am=%0b fin=%0b chan=%0d, got freq=%0d am=%0b fin=%0b chan=%0d",
                     want.freq, want.am, want.fin, want.chan,
                     frequency_o, tune_am_o, scan_finished_o, channel_count_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] v_low, v_high, v_stop, load;
    logic [STEP_W-1:0] v_step;
    logic [BAND_W-1:0] v_band;
    logic [CNT_W-1:0]  cnt;
    int unsigned       lo_b, hi_b, k, w;
    func_e             fn;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    func_i          = '0;
    accel_count_i   = '0;
    station_valid_i = 1'b0;
    load_value_i    = '0;
    fail_count      = 0;
    idle_pct        = 26;
    reg_low    = FREQ_LOW_RST;
    reg_high   = FREQ_HIGH_RST;
    reg_step   = STEP_RST;
    reg_band   = BAND_FM;
    reg_stop   = '0;
    tuned_freq = '0;
    chan_total = '0;

    // Reset values: FM band 8750..10800, step 10, stop at 0
    plan.push_back(row_known(FN_TUNE_CUR, 8'd0, 1'b0, 16'd0, 16'd8750, 1'b0, 1'b0, 8'd0));
    plan.push_back(row_known(FN_TUNE_UP, 8'd0, 1'b0, 16'd0, 16'd8760, 1'b0, 1'b0, 8'd0));
    plan.push_back(row_known(FN_TUNE_UP, 8'd255, 1'b0, 16'd0, 16'd8760, 1'b0, 1'b0, 8'd0));
    plan.push_back(row_cmd(FN_TUNE_UP, 8'd11, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_TUNE_DOWN, 8'd6, 1'b0, 16'd0));
    plan.push_back(row_known(FN_LOAD, 8'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'd0));
    plan.push_back(row_cmd(FN_TUNE_UP, 8'd1, 1'b0, 16'd0));  // wraps past 2^16, then clamps
    plan.push_back(row_known(FN_LOAD, 8'd0, 1'b0, 16'd10795, 16'd10795, 1'b0, 1'b0, 8'd0));
    plan.push_back(row_cmd(FN_SCAN_NEXT, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_NEXT, 8'd0, 1'b1, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_PREV, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_PREV, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_known(FN_SCAN_ALL, 8'd0, 1'b0, 16'd0, 16'd8750, 1'b0, 1'b1, 8'd255));
    plan.push_back(row_cmd(FN_ALIGN, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_known(FN_LOAD, 8'hAA, 1'b1, 16'h5555, 16'h5555, 1'b0, 1'b0, 8'd255));
    // MW band with the stop frequency on the grid
    plan.push_back(row_cfg(CFG_FREQ_LOW, 16'd522));
    plan.push_back(row_cfg(CFG_FREQ_HIGH, 16'd1620));
    plan.push_back(row_cfg(CFG_STEP_SIZE, 16'd9));
    plan.push_back(row_cfg(CFG_BAND, 16'(BAND_MW)));
    plan.push_back(row_cfg(CFG_STOP_FREQ, 16'd540));
    plan.push_back(row_known(FN_LOAD, 8'd0, 1'b0, 16'd530, 16'd530, 1'b1, 1'b0, 8'd255));
    plan.push_back(row_cmd(FN_ALIGN, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_NEXT, 8'd0, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_NEXT, 8'd0, 1'b0, 16'd0));  // lands on the stop frequency
    plan.push_back(row_known(FN_LOAD, 8'd0, 1'b0, 16'd500, 16'd500, 1'b1, 1'b0, 8'd255));
    plan.push_back(row_cmd(FN_ALIGN, 8'd0, 1'b0, 16'd0));      // below the band: moves up
    plan.push_back(row_cmd(FN_TUNE_UP, 8'd12, 1'b0, 16'd0));
    // Shortwave over the full range, largest step
    plan.push_back(row_cfg(CFG_FREQ_LOW, 16'd0));
    plan.push_back(row_cfg(CFG_FREQ_HIGH, 16'hFFFF));
    plan.push_back(row_cfg(CFG_STEP_SIZE, 16'd255));
    plan.push_back(row_cfg(CFG_BAND, 16'd2));
    plan.push_back(row_cfg(CFG_STOP_FREQ, 16'hFFFF));
    plan.push_back(row_cmd(FN_TUNE_UP, 8'd255, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_TUNE_DOWN, 8'd7, 1'b0, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_PREV, 8'd0, 1'b1, 16'd0));
    plan.push_back(row_cmd(FN_SCAN_ALL, 8'd0, 1'b0, 16'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].wdata);
      else send_command(plan[i]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin v_low = 16'd8750;  v_high = 16'd10800; v_step = 8'd10;  v_band = 4'd0;  v_stop = 16'd9800;  end
        1: begin v_low = 16'd522;   v_high = 16'd1620;  v_step = 8'd9;   v_band = 4'd1;  v_stop = 16'd999;   end
        2: begin v_low = 16'd2300;  v_high = 16'd26100; v_step = 8'd5;   v_band = 4'd15; v_stop = 16'd2300;  end
        3: begin v_low = 16'd0;     v_high = 16'hFFFF;  v_step = 8'd255; v_band = 4'd2;  v_stop = 16'hFFFF;  end
        4: begin v_low = 16'd40000; v_high = 16'd100;   v_step = 8'd1;   v_band = 4'd1;  v_stop = 16'd0;     end
        5: begin v_low = 16'd0;     v_high = 16'hFFFF;  v_step = 8'd1;   v_band = 4'd0;  v_stop = 16'd0;     end
        default: begin
          v_low  = 16'($urandom_range(60000));
          v_high = 16'(v_low + $urandom_range(5000));
          v_step = 8'($urandom_range(255, 1));
          v_band = 4'($urandom_range(15));
          v_stop = 16'(v_low + v_step * $urandom_range(20));
        end
      endcase
      write_reg(CFG_FREQ_LOW, v_low);
      write_reg(CFG_FREQ_HIGH, v_high);
      write_reg(CFG_STEP_SIZE, 16'(v_step));
      write_reg(CFG_BAND, 16'(v_band));
      write_reg(CFG_STOP_FREQ, v_stop);
      lo_b = (v_low <= v_high) ? v_low : v_high;
      hi_b = (v_low <= v_high) ? v_high : v_low;
      idle_pct = (ph == 5) ? 0 : 26;
      for (int n = 0; n < 250; n++) begin
        // at least half scans so that sweeps run through wraps and stop hits
        if ($urandom_range(1) == 1) fn = func_e'(3'($urandom_range(5, 3)));
        else fn = func_e'(3'($urandom_range(7)));
        cnt = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        k = $urandom_range(9);
        if (k < 4) load = 16'(v_low + v_step * $urandom_range(40));
        else if (k < 7) load = 16'($urandom_range(hi_b, lo_b));
        else load = 16'($urandom_range(16'hFFFF));
        send_command(row_cmd(fn, cnt, ($urandom_range(4) == 0), load));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    idle_pct = 26;
    for (w = 0; w < 100000 && pending_results.size() != 0; w++) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    fail_count += pending_results.size();
    if (fail_count == 0)
      $display("[radio_tuner_frequency_stepper] OK");
    else
      $display("[radio_tuner_frequency_stepper] ERROR");
    $finish;
  end

endmodule
